@@ hw/rtl/bpsa_pkg.sv @@
// Shared constants, codes and types of the permuted bit error rate counter.
`timescale 1ns / 1ps

package bpsa_pkg;

    // Store sizes.
    localparam int MAX_SLOTS   = 1024;
    localparam int MAX_STREAMS = 8;
    localparam int MAX_PERMS   = 32;

    // Widths of addresses, indexes and counts.
    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int STREAM_W = $clog2(MAX_STREAMS);
    localparam int PERM_W   = $clog2(MAX_PERMS);
    localparam int MAP_W    = 3 * MAX_STREAMS;
    localparam int BITS_W   = 8;
    localparam int LEN_W    = 11;
    localparam int SCNT_W   = 4;
    localparam int PCNT_W   = 6;
    localparam int ERR_W    = 14;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 3;

    // Commands carried by an input beat.
    typedef enum logic [1:0] {
        CMD_LOAD_SLOT = 2'd0,
        CMD_LOAD_PERM = 2'd1,
        CMD_COMPUTE   = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_START   = 3'd0,
        REG_DETECTED_START = 3'd1,
        REG_COMPARE_LENGTH = 3'd2,
        REG_STREAM_COUNT   = 3'd3,
        REG_PERM_COUNT     = 3'd4
    } t_reg_idx;

    // Operations of the shared error accumulator.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_INIT,
        ACC_PERM_CLR,
        ACC_STREAM_CLR,
        ACC_ADD,
        ACC_STREAM_END,
        ACC_PERM_END
    } t_acc_op;

    // Control bundle from the sequencer to the accumulator.
    typedef struct packed {
        t_acc_op             op;
        logic                mism;
        logic [LEN_W-1:0]    len;
        logic [STREAM_W-1:0] s_idx;
        logic [PERM_W-1:0]   p_idx;
        logic [ERR_W-1:0]    init;
    } t_acc_ctl;

endpackage

@@ hw/rtl/bpsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bpsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bpsa_acc.sv @@
// Shared error accumulator: counts mismatches, picks the sign and tracks the best permutation.
`timescale 1ns / 1ps

module bpsa_acc import bpsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_acc_ctl               i_ctl,
    output logic [ERR_W-1:0]       o_best_errors,
    output logic [PERM_W-1:0]      o_best_index,
    output logic [MAX_STREAMS-1:0] o_best_signs
);

    logic [LEN_W-1:0]       r_stream_errors;
    logic [ERR_W-1:0]       r_perm_errors;
    logic [ERR_W-1:0]       r_best_errors;
    logic [PERM_W-1:0]      r_best_index;
    logic [MAX_STREAMS-1:0] r_trial_signs;
    logic [MAX_STREAMS-1:0] r_best_signs;

    logic [LEN_W-1:0] w_inverted;
    logic             w_take_plain;
    logic [LEN_W-1:0] w_chosen;

    // Plain count against its complement; a tie goes to the inverted choice.
    assign w_inverted   = i_ctl.len - r_stream_errors;
    assign w_take_plain = (r_stream_errors < w_inverted);
    assign w_chosen     = w_take_plain ? r_stream_errors : w_inverted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_errors <= '0;
            r_perm_errors   <= '0;
            r_best_errors   <= '0;
            r_best_index    <= '0;
            r_trial_signs   <= '0;
            r_best_signs    <= '0;
        end else begin
            unique case (i_ctl.op)
                ACC_INIT: begin
                    r_best_errors <= i_ctl.init;
                    r_best_index  <= '0;
                    r_best_signs  <= '0;
                end
                ACC_PERM_CLR: begin
                    r_perm_errors <= '0;
                    r_trial_signs <= '0;
                end
                ACC_STREAM_CLR: begin
                    r_stream_errors <= '0;
                end
                ACC_ADD: begin
                    r_stream_errors <= r_stream_errors + LEN_W'(i_ctl.mism);
                end
                ACC_STREAM_END: begin
                    r_perm_errors <= r_perm_errors + ERR_W'(w_chosen);
                    if (!w_take_plain) begin
                        r_trial_signs[i_ctl.s_idx] <= 1'b1;
                    end
                end
                ACC_PERM_END: begin
                    if (r_perm_errors < r_best_errors) begin
                        r_best_errors <= r_perm_errors;
                        r_best_index  <= i_ctl.p_idx;
                        r_best_signs  <= r_trial_signs;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_best_errors = r_best_errors;
    assign o_best_index  = r_best_index;
    assign o_best_signs  = r_best_signs;

endmodule

@@ hw/rtl/ber_permutation_sign_ambiguity_top.sv @@
// Top level: command decode, configuration registers, compute sequencer and result register.
`timescale 1ns / 1ps

// Loads of a time slot or a permutation entry take one beat each and are accepted
// back to back, one per cycle, while no compute runs. A compute beat walks every
// permutation, every stream and every slot of the window through one read port of
// the slot store and one shared accumulator; the input stays not ready until the
// walk is done and its result has moved into the output register. The result waits
// in an output register, so loads may be taken while it is pending. Store entries
// read by a compute must have been loaded first.
module ber_permutation_sign_ambiguity_top import bpsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_command,
    input  logic [SLOT_W-1:0]      i_slot_index,
    input  logic [BITS_W-1:0]      i_source_bits,
    input  logic [BITS_W-1:0]      i_detected_bits,
    input  logic [PERM_W-1:0]      i_perm_index,
    input  logic [MAP_W-1:0]       i_perm_map,
    // Output channel.
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [ERR_W-1:0]       o_min_errors,
    output logic [ERR_W-1:0]       o_bits_compared,
    output logic [PERM_W-1:0]      o_best_perm,
    output logic [BITS_W-1:0]      o_best_signs,
    output logic                   o_range_error
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PRD,
        S_PWAIT,
        S_SCLR,
        S_SLOT,
        S_DRAIN,
        S_SEND,
        S_PEND,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [SLOT_W-1:0] r_cfg_src_start;
    logic [SLOT_W-1:0] r_cfg_det_start;
    logic [LEN_W-1:0]  r_cfg_len;
    logic [SCNT_W-1:0] r_cfg_streams;
    logic [PCNT_W-1:0] r_cfg_perms;

    // Loop counters and working registers.
    logic [PERM_W-1:0]   r_p;
    logic [STREAM_W-1:0] r_s;
    logic [SLOT_W-1:0]   r_t;
    logic [MAP_W-1:0]    r_map;
    logic                r_rd_vld;
    logic [ERR_W-1:0]    r_bits;

    // Result held until the output register is free.
    logic [ERR_W-1:0]  r_res_min;
    logic [ERR_W-1:0]  r_res_bits;
    logic [PERM_W-1:0] r_res_perm;
    logic [BITS_W-1:0] r_res_signs;
    logic              r_res_range;

    // Output register.
    logic              r_out_valid;
    logic [ERR_W-1:0]  r_out_min;
    logic [ERR_W-1:0]  r_out_bits;
    logic [PERM_W-1:0] r_out_perm;
    logic [BITS_W-1:0] r_out_signs;
    logic              r_out_range;

    logic                     w_in_fire;
    t_cmd                     w_cmd;
    logic [SCNT_W-1:0]        w_streams;
    logic [PCNT_W-1:0]        w_perms;
    logic [SLOT_W+1:0]        w_src_end;
    logic [SLOT_W+1:0]        w_det_end;
    logic                     w_range_bad;
    logic [LEN_W+SCNT_W-1:0]  w_prod;
    logic [ERR_W-1:0]         w_bits;
    logic [SLOT_W-1:0]        w_len_m1;
    logic [STREAM_W-1:0]      w_s_last;
    logic [PERM_W-1:0]        w_p_last;
    logic [SLOT_W-1:0]        w_src_addr;
    logic [SLOT_W-1:0]        w_det_addr;
    logic [2*BITS_W-1:0]      w_slot_q;
    logic [MAP_W-1:0]         w_perm_q;
    logic                     w_src_bit;
    logic                     w_det_bit;
    t_acc_ctl                 w_ctl;
    logic [ERR_W-1:0]         w_best_errors;
    logic [PERM_W-1:0]        w_best_index;
    logic [MAX_STREAMS-1:0]   w_best_signs;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_cmd      = t_cmd'(i_command);

    // Saturated counts and window checks.
    assign w_streams = (r_cfg_streams > SCNT_W'(MAX_STREAMS)) ? SCNT_W'(MAX_STREAMS)
                                                              : r_cfg_streams;
    assign w_perms   = (r_cfg_perms > PCNT_W'(MAX_PERMS)) ? PCNT_W'(MAX_PERMS)
                                                          : r_cfg_perms;
    assign w_src_end = {2'b00, r_cfg_src_start} + {1'b0, r_cfg_len};
    assign w_det_end = {2'b00, r_cfg_det_start} + {1'b0, r_cfg_len};
    assign w_range_bad = (w_src_end > (SLOT_W+2)'(MAX_SLOTS))
                      || (w_det_end > (SLOT_W+2)'(MAX_SLOTS));
    assign w_prod = {{SCNT_W{1'b0}}, r_cfg_len} * {{LEN_W{1'b0}}, w_streams};
    assign w_bits = w_prod[ERR_W-1:0];

    // Last values of the three loop counters.
    assign w_len_m1 = SLOT_W'(r_cfg_len - LEN_W'(1));
    assign w_s_last = STREAM_W'(w_streams - SCNT_W'(1));
    assign w_p_last = PERM_W'(w_perms - PCNT_W'(1));

    // Slot store: source bits in the low byte, detected bits in the high byte.
    assign w_src_addr = r_cfg_src_start + r_t;
    assign w_det_addr = r_cfg_det_start + r_t;

    bpsa_ram #(
        .WIDTH(BITS_W),
        .DEPTH(MAX_SLOTS)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_fire && (w_cmd == CMD_LOAD_SLOT)),
        .i_waddr (i_slot_index),
        .i_wdata (i_source_bits),
        .i_raddr (w_src_addr),
        .o_rdata (w_slot_q[BITS_W-1:0])
    );

    bpsa_ram #(
        .WIDTH(BITS_W),
        .DEPTH(MAX_SLOTS)
    ) u_det_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_fire && (w_cmd == CMD_LOAD_SLOT)),
        .i_waddr (i_slot_index),
        .i_wdata (i_detected_bits),
        .i_raddr (w_det_addr),
        .o_rdata (w_slot_q[2*BITS_W-1:BITS_W])
    );

    // Permutation table.
    bpsa_ram #(
        .WIDTH(MAP_W),
        .DEPTH(MAX_PERMS)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_fire && (w_cmd == CMD_LOAD_PERM)),
        .i_waddr (i_perm_index),
        .i_wdata (i_perm_map),
        .i_raddr (r_p),
        .o_rdata (w_perm_q)
    );

    // Source bit of the current stream against its mapped detected stream.
    assign w_src_bit = w_slot_q[{1'b0, r_s}];
    assign w_det_bit = w_slot_q[{1'b1, r_map[{2'b00, r_s} * 5'd3 +: 3]}];

    // Accumulator control: a returning slot read always adds, otherwise the state decides.
    always_comb begin
        w_ctl       = '0;
        w_ctl.op    = ACC_NONE;
        w_ctl.mism  = w_src_bit ^ w_det_bit;
        w_ctl.len   = r_cfg_len;
        w_ctl.s_idx = r_s;
        w_ctl.p_idx = r_p;
        w_ctl.init  = w_bits + ERR_W'(1);
        if (r_rd_vld) begin
            w_ctl.op = ACC_ADD;
        end else begin
            unique case (r_state)
                S_CHECK: w_ctl.op = ACC_INIT;
                S_PWAIT: w_ctl.op = ACC_PERM_CLR;
                S_SCLR:  w_ctl.op = ACC_STREAM_CLR;
                S_SEND:  w_ctl.op = ACC_STREAM_END;
                S_PEND:  w_ctl.op = ACC_PERM_END;
                default: w_ctl.op = ACC_NONE;
            endcase
        end
    end

    bpsa_acc u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_best_errors (w_best_errors),
        .o_best_index  (w_best_index),
        .o_best_signs  (w_best_signs)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_src_start <= '0;
            r_cfg_det_start <= '0;
            r_cfg_len       <= '0;
            r_cfg_streams   <= SCNT_W'(8);
            r_cfg_perms     <= PCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SOURCE_START:   r_cfg_src_start <= i_cfg_data[SLOT_W-1:0];
                REG_DETECTED_START: r_cfg_det_start <= i_cfg_data[SLOT_W-1:0];
                REG_COMPARE_LENGTH: r_cfg_len       <= i_cfg_data[LEN_W-1:0];
                REG_STREAM_COUNT:   r_cfg_streams   <= i_cfg_data[SCNT_W-1:0];
                REG_PERM_COUNT:     r_cfg_perms     <= i_cfg_data[PCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Compute sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_p         <= '0;
            r_s         <= '0;
            r_t         <= '0;
        end else begin
            r_rd_vld <= (r_state == S_SLOT);
            // A taken result frees the output register unless a new one loads now.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire && (w_cmd == CMD_COMPUTE)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_min   <= '0;
                    r_res_bits  <= '0;
                    r_res_perm  <= '0;
                    r_res_signs <= '0;
                    r_res_range <= (w_streams != '0) && w_range_bad;
                    r_bits      <= w_bits;
                    r_p         <= '0;
                    if (w_streams == '0) begin
                        r_state <= S_DONE;
                    end else if (w_range_bad) begin
                        r_state <= S_DONE;
                    end else if (w_perms == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    r_map   <= w_perm_q;
                    r_s     <= '0;
                    r_state <= S_SCLR;
                end
                S_SCLR: begin
                    r_t <= '0;
                    if (r_cfg_len == '0) begin
                        r_state <= S_SEND;
                    end else begin
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    r_t <= r_t + SLOT_W'(1);
                    if (r_t == w_len_m1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (r_s == w_s_last) begin
                        r_state <= S_PEND;
                    end else begin
                        r_s     <= r_s + STREAM_W'(1);
                        r_state <= S_SCLR;
                    end
                end
                S_PEND: begin
                    if (r_p == w_p_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_p     <= r_p + PERM_W'(1);
                        r_state <= S_PRD;
                    end
                end
                S_FIN: begin
                    r_res_min   <= w_best_errors;
                    r_res_bits  <= r_bits;
                    r_res_perm  <= w_best_index;
                    r_res_signs <= BITS_W'(w_best_signs);
                    r_res_range <= 1'b0;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_min   <= r_res_min;
                        r_out_bits  <= r_res_bits;
                        r_out_perm  <= r_res_perm;
                        r_out_signs <= r_res_signs;
                        r_out_range <= r_res_range;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_min_errors    = r_out_min;
    assign o_bits_compared = r_out_bits;
    assign o_best_perm     = r_out_perm;
    assign o_best_signs    = r_out_signs;
    assign o_range_error   = r_out_range;

    // A range error result carries no counts.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_min_errors == '0 && o_bits_compared == '0))
        else $error("range error result with nonzero counts");

    // The best count never exceeds the bits compared plus one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_range_error) |-> ({1'b0, o_min_errors} <= {1'b0, o_bits_compared} + 15'd1))
        else $error("error count beyond bits compared");

    // An accepted compute beat closes the input until its result is queued.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command == CMD_COMPUTE) |=> !o_in_ready)
        else $error("input ready right after a compute beat");

    // Slot reads return only while the slot walk or its drain is running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SLOT || r_state == S_DRAIN))
        else $error("slot read returned outside the slot walk");

endmodule

@@ tb/ber_permutation_sign_ambiguity_top_tb.sv @@
// Self-checking testbench for the permuted bit error rate counter with sign ambiguity.
`timescale 1ns / 1ps

module ber_permutation_sign_ambiguity_top_tb;
    import bpsa_pkg::*;

    localparam int LIMIT_NS = 12_000_000;

    // One result beat, packed in the order of the output ports.
    typedef struct packed {
        logic [ERR_W-1:0]  min_errors;
        logic [ERR_W-1:0]  bits_compared;
        logic [PERM_W-1:0] best_perm;
        logic [BITS_W-1:0] best_signs;
        logic              range_error;
    } ber_result_t;

    // Mirror of the block: stores, permutation table and window registers. Every accepted
    // compute beat is turned into an expected result right away.
    class ber_tally;
        logic [BITS_W-1:0] src_mem [MAX_SLOTS];
        logic [BITS_W-1:0] det_mem [MAX_SLOTS];
        logic [MAP_W-1:0]  perm_mem [MAX_PERMS];
        logic [SLOT_W-1:0] src_start;
        logic [SLOT_W-1:0] det_start;
        logic [LEN_W-1:0]  cmp_len;
        logic [SCNT_W-1:0] n_streams;
        logic [PCNT_W-1:0] n_perms;
        ber_result_t       pending_results [$];
        int                errors;
        int                computes;
        int                range_hits;
        int                loads;

        function new();
            src_start  = '0;
            det_start  = '0;
            cmp_len    = '0;
            n_streams  = SCNT_W'(8);
            n_perms    = PCNT_W'(1);
            errors     = 0;
            computes   = 0;
            range_hits = 0;
            loads      = 0;
        endfunction

        function void write_reg(t_reg_idx idx, int value);
            case (idx)
                REG_SOURCE_START:   src_start = value[SLOT_W-1:0];
                REG_DETECTED_START: det_start = value[SLOT_W-1:0];
                REG_COMPARE_LENGTH: cmp_len   = value[LEN_W-1:0];
                REG_STREAM_COUNT:   n_streams = value[SCNT_W-1:0];
                REG_PERM_COUNT:     n_perms   = value[PCNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Walk every permutation and stream over the window, as the block does.
        function ber_result_t tally_errors();
            ber_result_t       res;
            int                streams, perms, bits, best_err, plain, inv, perr;
            logic [PERM_W-1:0] best_p;
            logic [BITS_W-1:0] best_sg, trial_sg, sw, dw;
            logic [2:0]        tgt;
            res = '0;
            streams = (int'(n_streams) > MAX_STREAMS) ? MAX_STREAMS : int'(n_streams);
            if (streams == 0) return res;
            if (int'(src_start) + int'(cmp_len) > MAX_SLOTS ||
                    int'(det_start) + int'(cmp_len) > MAX_SLOTS) begin
                res.range_error = 1'b1;
                return res;
            end
            perms = (int'(n_perms) > MAX_PERMS) ? MAX_PERMS : int'(n_perms);
            bits = int'(cmp_len) * streams;
            best_err = bits + 1;
            best_p = '0;
            best_sg = '0;
            for (int p = 0; p < perms; p++) begin
                perr = 0;
                trial_sg = '0;
                for (int s = 0; s < streams; s++) begin
                    tgt = perm_mem[p][3*s +: 3];
                    plain = 0;
                    for (int t = 0; t < int'(cmp_len); t++) begin
                        sw = src_mem[int'(src_start) + t];
                        dw = det_mem[int'(det_start) + t];
                        plain += int'(sw[s] ^ dw[tgt]);
                    end
                    inv = int'(cmp_len) - plain;
                    // A tie goes to the inverted reading.
                    if (plain < inv) begin
                        perr += plain;
                    end else begin
                        perr += inv;
                        trial_sg[s] = 1'b1;
                    end
                end
                if (perr < best_err) begin
                    best_err = perr;
                    best_p = PERM_W'(p);
                    best_sg = trial_sg;
                end
            end
            res.min_errors    = best_err[ERR_W-1:0];
            res.bits_compared = bits[ERR_W-1:0];
            res.best_perm     = best_p;
            res.best_signs    = best_sg;
            return res;
        endfunction

        function void note_beat(t_cmd cmd, logic [SLOT_W-1:0] slot, logic [BITS_W-1:0] src,
                                logic [BITS_W-1:0] det, logic [PERM_W-1:0] pidx,
                                logic [MAP_W-1:0] pmap);
            ber_result_t res;
            case (cmd)
                CMD_LOAD_SLOT: begin
                    src_mem[slot] = src;
                    det_mem[slot] = det;
                    loads++;
                end
                CMD_LOAD_PERM: begin
                    perm_mem[pidx] = pmap;
                    loads++;
                end
                CMD_COMPUTE: begin
                    res = tally_errors();
                    if (res.range_error) range_hits++;
                    computes++;
                    pending_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string name, logic [ERR_W-1:0] exp, logic [ERR_W-1:0] act);
            if (act !== exp) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(ber_result_t got);
            ber_result_t exp;
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no compute outstanding");
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            cmp_field("min_errors", exp.min_errors, got.min_errors);
            cmp_field("bits_compared", exp.bits_compared, got.bits_compared);
            cmp_field("best_perm", ERR_W'(exp.best_perm), ERR_W'(got.best_perm));
            cmp_field("best_signs", ERR_W'(exp.best_signs), ERR_W'(got.best_signs));
            cmp_field("range_error", ERR_W'(exp.range_error), ERR_W'(got.range_error));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_command = '0;
    logic [SLOT_W-1:0]    i_slot_index = '0;
    logic [BITS_W-1:0]    i_source_bits = '0;
    logic [BITS_W-1:0]    i_detected_bits = '0;
    logic [PERM_W-1:0]    i_perm_index = '0;
    logic [MAP_W-1:0]     i_perm_map = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ERR_W-1:0]     o_min_errors;
    logic [ERR_W-1:0]     o_bits_compared;
    logic [PERM_W-1:0]    o_best_perm;
    logic [BITS_W-1:0]    o_best_signs;
    logic                 o_range_error;

    ber_tally    sb;
    ber_result_t seen_beat;
    bit          calm = 1'b0;
    int          beats_sent = 0;
    int          reg_writes = 0;

    ber_permutation_sign_ambiguity_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_slot_index    (i_slot_index),
        .i_source_bits   (i_source_bits),
        .i_detected_bits (i_detected_bits),
        .i_perm_index    (i_perm_index),
        .i_perm_map      (i_perm_map),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_min_errors    (o_min_errors),
        .o_bits_compared (o_bits_compared),
        .o_best_perm     (o_best_perm),
        .o_best_signs    (o_best_signs),
        .o_range_error   (o_range_error)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    assign seen_beat = {o_min_errors, o_bits_compared, o_best_perm, o_best_signs,
                        o_range_error};

    // Check every result beat taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_result(seen_beat);
    end

    // Result side back-pressure: random stall bursts, none in the final stretch.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (calm || !i_rst_n) begin
                i_out_ready = calm;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Run limit for a hung block.
    initial begin
        #LIMIT_NS;
        $display("DONE: errors detected");
        $finish;
    end

    // Present one input beat and hold it until the block takes it.
    task automatic send_beat(t_cmd cmd, logic [SLOT_W-1:0] slot, logic [BITS_W-1:0] src,
                             logic [BITS_W-1:0] det, logic [PERM_W-1:0] pidx,
                             logic [MAP_W-1:0] pmap);
        if (!calm && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_command       = cmd;
        i_slot_index    = slot;
        i_source_bits   = src;
        i_detected_bits = det;
        i_perm_index    = pidx;
        i_perm_map      = pmap;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note_beat(cmd, slot, src, det, pidx, pmap);
        if (cmd != CMD_NONE) beats_sent++;
    endtask

    task automatic load_slot(int slot, logic [BITS_W-1:0] src, logic [BITS_W-1:0] det);
        send_beat(CMD_LOAD_SLOT, SLOT_W'(slot), src, det, PERM_W'($urandom), MAP_W'($urandom));
    endtask

    task automatic load_perm(int idx, logic [MAP_W-1:0] map);
        send_beat(CMD_LOAD_PERM, SLOT_W'($urandom), BITS_W'($urandom), BITS_W'($urandom),
                  PERM_W'(idx), map);
    endtask

    task automatic send_compute();
        send_beat(CMD_COMPUTE, SLOT_W'($urandom), BITS_W'($urandom), BITS_W'($urandom),
                  PERM_W'($urandom), MAP_W'($urandom));
    endtask

    // Ignored command code with random payload.
    task automatic send_noise();
        send_beat(CMD_NONE, SLOT_W'($urandom), BITS_W'($urandom), BITS_W'($urandom),
                  PERM_W'($urandom), MAP_W'($urandom));
    endtask

    // Drop valid, wait for every outstanding result, then let the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic put_reg(t_reg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_W'(value);
        sb.write_reg(idx, value);
        reg_writes++;
    endtask

    // Program the whole window while the block is idle.
    task automatic set_window(int ss, int ds, int len, int sc, int pc);
        settle();
        put_reg(REG_SOURCE_START, ss);
        put_reg(REG_DETECTED_START, ds);
        put_reg(REG_COMPARE_LENGTH, len);
        put_reg(REG_STREAM_COUNT, sc);
        put_reg(REG_PERM_COUNT, pc);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // A random map that sends the eight source streams to distinct detected streams.
    function automatic logic [MAP_W-1:0] shuffled_map();
        int               order [MAX_STREAMS];
        int               j, tmp;
        logic [MAP_W-1:0] m;
        for (int k = 0; k < MAX_STREAMS; k++) order[k] = k;
        for (int k = MAX_STREAMS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        m = '0;
        for (int k = 0; k < MAX_STREAMS; k++) m[3*k +: 3] = 3'(order[k]);
        return m;
    endfunction

    // One random phase: a new window; when it fits and both starts match, a detected window
    // that is a permuted and partly inverted copy of the source with some bit errors; a
    // table holding the true map, a compute, then a few loose beats.
    task automatic run_phase();
        int               ss, ds, len, sc, pc, peff, r, true_pos, n;
        logic [MAP_W-1:0] true_map, map;
        logic [BITS_W-1:0] signs, src, det;
        logic [2:0]       tgt;
        bit               off_end;

        sc = $urandom_range(1, 8);
        r = $urandom_range(0, 9);
        if (r == 0) sc = 0;
        else if (r == 1) sc = $urandom_range(9, 15);
        pc = $urandom_range(1, 6);
        r = $urandom_range(0, 11);
        if (r == 0) pc = 0;
        else if (r == 1) pc = $urandom_range(33, 63);
        else if (r == 2) pc = 32;
        else if (r == 3) pc = $urandom_range(7, 31);
        peff = (pc > MAX_PERMS) ? MAX_PERMS : pc;
        len = $urandom_range(0, 24);
        if ($urandom_range(0, 7) == 0) len = $urandom_range(25, 64);
        // Keep long walks rare: many permutations only over short windows.
        if (peff > 8) begin
            len = $urandom_range(0, 8);
        end else if (len > 24 && peff > 4) begin
            pc = $urandom_range(1, 4);
            peff = pc;
        end

        off_end = ($urandom_range(0, 9) == 0);
        if (off_end) begin
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(MAX_SLOTS + 1, 2047);
                ss = $urandom_range(0, MAX_SLOTS - 1);
                ds = $urandom_range(0, MAX_SLOTS - 1);
            end else begin
                len = $urandom_range(1, 64);
                if ($urandom_range(0, 1) == 0) begin
                    ss = $urandom_range(MAX_SLOTS + 1 - len, MAX_SLOTS - 1);
                    ds = $urandom_range(0, MAX_SLOTS - len);
                end else begin
                    ds = $urandom_range(MAX_SLOTS + 1 - len, MAX_SLOTS - 1);
                    ss = $urandom_range(0, MAX_SLOTS - len);
                end
            end
        end else begin
            ss = $urandom_range(0, MAX_SLOTS - len);
            ds = ($urandom_range(0, 2) != 0) ? ss : $urandom_range(0, MAX_SLOTS - len);
        end
        set_window(ss, ds, len, sc, pc);

        true_map = shuffled_map();
        signs = BITS_W'($urandom);
        if (!off_end && ss == ds) begin
            for (int t = 0; t < len; t++) begin
                src = BITS_W'($urandom);
                det = BITS_W'($urandom);
                for (int s = 0; s < MAX_STREAMS; s++) begin
                    tgt = true_map[3*s +: 3];
                    det[tgt] = src[s] ^ signs[s] ^ ($urandom_range(0, 15) == 0);
                end
                load_slot(ss + t, src, det);
            end
        end

        // Table entries: the true map at a random place, copies of it, and decoys.
        if (peff > 0) begin
            true_pos = $urandom_range(0, peff - 1);
            if (peff <= 8) begin
                for (int p = 0; p < peff; p++) begin
                    r = $urandom_range(0, 3);
                    map = (r == 0) ? true_map : (r == 1) ? MAP_W'($urandom) : shuffled_map();
                    load_perm(p, (p == true_pos) ? true_map : map);
                end
            end else begin
                repeat (4) load_perm($urandom_range(0, MAX_PERMS - 1), shuffled_map());
                load_perm(true_pos, true_map);
            end
        end
        send_compute();

        n = $urandom_range(0, 8);
        repeat (n) begin
            r = $urandom_range(0, 19);
            if (r <= 8)
                load_slot($urandom_range(0, MAX_SLOTS - 1), BITS_W'($urandom),
                          BITS_W'($urandom));
            else if (r <= 11)
                load_perm($urandom_range(0, MAX_PERMS - 1),
                          ($urandom_range(0, 1) == 0) ? MAP_W'($urandom) : shuffled_map());
            else if (r <= 17)
                send_compute();
            else
                send_noise();
        end
    endtask

    // Main sequence.
    initial begin
        logic [MAP_W-1:0]  ident;
        logic [BITS_W-1:0] src, det;
        int                base;

        sb = new();
        ident = '0;
        for (int k = 0; k < MAX_STREAMS; k++) ident[3*k +: 3] = 3'(k);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every slot and table entry so that no compute reads an unwritten one.
        // The low slots hold equal source and detected bits; the ends hold all-ones
        // and all-zeros patterns.
        for (int k = 0; k < MAX_SLOTS; k++) begin
            src = BITS_W'($urandom);
            det = (k < 32) ? src : BITS_W'($urandom);
            if (k == 0) begin
                src = '0;
                det = '0;
            end else if (k == 1) begin
                src = '1;
                det = '1;
            end else if (k == MAX_SLOTS - 2) begin
                src = '0;
                det = '1;
            end else if (k == MAX_SLOTS - 1) begin
                src = '1;
                det = '0;
            end
            load_slot(k, src, det);
        end
        for (int p = 0; p < MAX_PERMS; p++) begin
            if (p == 0 || p == 3) load_perm(p, ident);
            else if (p == 1) load_perm(p, '0);
            else if (p == 2) load_perm(p, '1);
            else load_perm(p, shuffled_map());
        end

        // Directed part. Compute with the reset window: nothing compared, all ties.
        send_compute();
        // Clean window, identity first and repeated later: the first one wins.
        set_window(0, 0, 16, 8, 4);
        send_compute();
        send_noise();
        load_perm(MAX_PERMS - 1, '1);
        load_perm(MAX_PERMS - 2, '0);
        load_slot(2, '1, '0);
        // Full-length window.
        set_window(0, 0, MAX_SLOTS, 8, 2);
        send_compute();
        // Windows running off the end of the stores.
        set_window(MAX_SLOTS - 1, 0, 2, 8, 1);
        send_compute();
        set_window(0, MAX_SLOTS - 1, 2, 8, 1);
        send_compute();
        set_window(0, 0, 2047, 8, 1);
        send_compute();
        // No streams in use.
        set_window(5, 9, 7, 0, 3);
        send_compute();
        // Stream and permutation counts above their limits.
        set_window(0, 0, 4, 15, 63);
        send_compute();
        // No permutations tried.
        set_window(0, 0, 5, 3, 0);
        send_compute();
        // Single slot at the very end of both stores.
        set_window(MAX_SLOTS - 1, MAX_SLOTS - 1, 1, 1, 1);
        send_compute();
        // Every table entry over a shifted window.
        set_window(1000, 24, 24, 8, MAX_PERMS);
        send_compute();

        // Random phases; the last stretch runs without idling on either side.
        base = beats_sent;
        while (beats_sent - base < 150) begin
            calm = (beats_sent - base > 100);
            run_phase();
        end
        calm = 1'b1;

        settle();
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d compute results, %0d with the window off the end,",
                 sb.computes, sb.range_hits);
        $display("over %0d load beats and %0d register writes.", sb.loads, reg_writes);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
